[sv/hptc_pkg.sv]
// Types, constants and register codes shared by the heading turn controller.
package hptc_pkg;

    // Sensor slots and field widths
    localparam int SENS_NUM    = 4;
    localparam int ANGLE_W     = 32;
    localparam int SPEED_W     = 15;
    localparam int GAIN_W      = 20;
    localparam int WIN_W       = 16;
    localparam int TICK_W      = 16;
    localparam int INTEG_W     = 40;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_IDX_W   = 4;
    localparam int DRIVE_W     = 16;

    // Datapath widths derived from the fields
    localparam int IDX_W       = (SENS_NUM > 1) ? $clog2(SENS_NUM) : 1;
    localparam int SUM_W       = ANGLE_W + IDX_W;
    localparam int CNT_W       = $clog2(SENS_NUM + 1);
    localparam int DIV_STEPS   = 8;
    localparam int DIV_W       = ((SUM_W + DIV_STEPS - 1) / DIV_STEPS) * DIV_STEPS;
    localparam int DIV_CYC     = DIV_W / DIV_STEPS;
    localparam int CHUNK_W     = 20;
    localparam int MAG_W       = 2 * CHUNK_W;
    localparam int PROD_W      = GAIN_W + CHUNK_W;
    localparam int ACC_W       = 62;
    localparam int TERM_NUM    = 3;
    localparam int MUL_STEPS   = 2 * TERM_NUM;
    localparam int RND_SHIFT   = 16;
    localparam int RND_W       = ACC_W - RND_SHIFT;

    // Angle and limit constants, 1/256 degree
    localparam int HALF_TURN    = 46080;
    localparam int FULL_TURN    = 92160;
    localparam int DERIV_SETTLE = 128;
    localparam logic signed [INTEG_W-1:0] INTEG_LIMIT = 40'sd549755813887;

    // Register reset values
    localparam logic signed [ANGLE_W-1:0] RST_TARGET  = '0;
    localparam logic [SPEED_W-1:0]        RST_MAX     = 15'd25600;
    localparam logic [GAIN_W-1:0]         RST_GAIN_P  = 20'd39322;
    localparam logic [GAIN_W-1:0]         RST_GAIN_I  = 20'd131;
    localparam logic [GAIN_W-1:0]         RST_GAIN_D  = 20'd26214;
    localparam logic [WIN_W-1:0]          RST_WINDOW  = 16'd3840;
    localparam logic [WIN_W-1:0]          RST_SETTLE  = 16'd256;
    localparam logic [TICK_W-1:0]         RST_TIMEOUT = 16'd150;

    // Register indexes
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_TARGET  = 4'd0;
    localparam cfg_idx_t REG_MAX     = 4'd1;
    localparam cfg_idx_t REG_GAIN_P  = 4'd2;
    localparam cfg_idx_t REG_GAIN_I  = 4'd3;
    localparam cfg_idx_t REG_GAIN_D  = 4'd4;
    localparam cfg_idx_t REG_WINDOW  = 4'd5;
    localparam cfg_idx_t REG_SETTLE  = 4'd6;
    localparam cfg_idx_t REG_TIMEOUT = 4'd7;

    // Turn status codes
    typedef enum logic [1:0] {
        STAT_RUN     = 2'd0,
        STAT_SETTLED = 2'd1,
        STAT_TIMEOUT = 2'd2,
        STAT_NOSENS  = 2'd3
    } status_t;

    // One control tick request
    typedef struct packed {
        logic                      start_turn;
        logic signed [ANGLE_W-1:0] sensor_one_angle;
        logic signed [ANGLE_W-1:0] sensor_two_angle;
        logic signed [ANGLE_W-1:0] sensor_three_angle;
        logic signed [ANGLE_W-1:0] sensor_four_angle;
        logic                      sensor_one_present;
        logic                      sensor_two_present;
        logic                      sensor_three_present;
        logic                      sensor_four_present;
    } in_t;

    // One drive result
    typedef struct packed {
        logic signed [DRIVE_W-1:0] turn_speed;
        status_t                   turn_status;
        logic                      stop_brake;
    } out_t;

endpackage

[sv/heading_pid_turn_controller.sv]
// Heading PID turn controller: sequenced datapath with one shared multiplier.
//
//  Channel  | Handshake              | Payload
//  ---------+------------------------+----------------------------------
//  in       | in_valid / in_stall    | in_data  (hptc_pkg::in_t)
//  out      | out_valid / out_stall  | out_data (hptc_pkg::out_t)
//  cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A request runs from acceptance to result through 4 sensor summing steps,
// 5 divider steps (8 quotient bits each), 3 error/integral steps, 6 passes of
// the shared 20x20 multiplier plus one drain, and 3 rounding/output steps.
// With no sensor present the summing steps lead straight to the output step.
// in_stall is high from acceptance until the result moves into the output
// register; a result waiting on out_stall does not block the next request.
// Reset restores the register defaults and clears integral, error and ticks.
module heading_pid_turn_controller (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  hptc_pkg::in_t                          in_data,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output hptc_pkg::out_t                         out_data,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  hptc_pkg::cfg_idx_t                     cfg_index,
    input  logic [hptc_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import hptc_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_SUM   = 11'b000_0000_0010,
        S_DIV   = 11'b000_0000_0100,
        S_ERR   = 11'b000_0000_1000,
        S_WRAP  = 11'b000_0001_0000,
        S_INTEG = 11'b000_0010_0000,
        S_MUL   = 11'b000_0100_0000,
        S_DRAIN = 11'b000_1000_0000,
        S_RND1  = 11'b001_0000_0000,
        S_RND2  = 11'b010_0000_0000,
        S_FIN   = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers
    logic signed [ANGLE_W-1:0] target_reg;
    logic [SPEED_W-1:0]        max_reg;
    logic [GAIN_W-1:0]         gain_p_reg, gain_i_reg, gain_d_reg;
    logic [WIN_W-1:0]          window_reg, settle_reg;
    logic [TICK_W-1:0]         timeout_reg;

    // Controller state
    logic signed [INTEG_W-1:0] integ_reg;
    logic signed [ANGLE_W-1:0] prev_reg;
    logic [TICK_W-1:0]         tick_reg;

    // Sequencer counters and flags
    logic [IDX_W-1:0]          idx_reg;
    logic [$clog2(DIV_CYC+1)-1:0] div_cnt_reg;
    logic [$clog2(MUL_STEPS)-1:0] mul_step_reg;
    logic                      prod_vld_reg;
    logic                      nosens_reg;
    logic                      out_valid_reg;

    // Datapath registers
    logic signed [ANGLE_W-1:0] ang_reg [SENS_NUM];
    logic [SENS_NUM-1:0]       pres_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      sum_neg_reg;
    logic [DIV_W-1:0]          div_reg;
    logic [CNT_W-1:0]          rem_reg;
    logic signed [SUM_W:0]     diff_reg;
    logic signed [ANGLE_W-1:0] err_reg;
    logic [ANGLE_W:0]          err_mag_reg;
    logic signed [ANGLE_W:0]   deriv_reg;
    logic [PROD_W-1:0]         prod_reg;
    logic                      prod_neg_reg;
    logic                      prod_hi_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic                      tot_neg_reg;
    logic [ACC_W-1:0]          tot_mag_reg;
    logic signed [DRIVE_W-1:0] speed_reg;
    out_t                      out_reg;

    logic in_accept, out_take, fin_load;
    assign in_accept = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign fin_load  = (state_reg == S_FIN) && (!out_valid_reg || !out_stall);

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Sum one sensor slot per cycle
    logic signed [SUM_W-1:0] sum_add;
    logic [CNT_W-1:0]        cnt_add;
    logic [SUM_W-1:0]        sum_mag;
    always_comb
    begin
        sum_add = sum_reg;
        cnt_add = cnt_reg;
        if (pres_reg[idx_reg])
        begin
            sum_add = sum_reg + SUM_W'(ang_reg[idx_reg]);
            cnt_add = cnt_reg + CNT_W'(1);
        end
        sum_mag = sum_add[SUM_W-1] ? SUM_W'(-sum_add) : SUM_W'(sum_add);
    end

    // Divide the sum magnitude by the count, several quotient bits per cycle
    logic [DIV_W-1:0] div_next;
    logic [CNT_W-1:0] rem_next;
    always_comb
    begin
        logic [CNT_W:0] trial;
        div_next = div_reg;
        rem_next = rem_reg;
        trial    = '0;
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            trial    = {rem_next, div_next[DIV_W-1]};
            div_next = {div_next[DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, cnt_reg})
            begin
                trial       = trial - {1'b0, cnt_reg};
                div_next[0] = 1'b1;
            end
            rem_next = trial[CNT_W-1:0];
        end
    end

    // Heading average with truncation toward zero
    logic signed [SUM_W-1:0] avg;
    assign avg = sum_neg_reg ? -$signed(div_reg[SUM_W-1:0]) : $signed(div_reg[SUM_W-1:0]);

    // Wrap once, then saturate to the angle range
    logic signed [SUM_W:0]     wrapped;
    logic signed [ANGLE_W-1:0] err_sat;
    always_comb
    begin
        wrapped = diff_reg;
        if (diff_reg > (SUM_W+1)'(HALF_TURN))
            wrapped = diff_reg - (SUM_W+1)'(FULL_TURN);
        else if (diff_reg < -(SUM_W+1)'(HALF_TURN))
            wrapped = diff_reg + (SUM_W+1)'(FULL_TURN);
        if (wrapped > (SUM_W+1)'(32'sh7fff_ffff))
            err_sat = 32'sh7fff_ffff;
        else if (wrapped < (SUM_W+1)'(32'sh8000_0000))
            err_sat = 32'sh8000_0000;
        else
            err_sat = wrapped[ANGLE_W-1:0];
    end

    // Windowed, saturating integral and derivative
    logic [ANGLE_W:0]           err_mag;
    logic signed [INTEG_W:0]    integ_sum;
    logic signed [INTEG_W-1:0]  integ_next;
    always_comb
    begin
        err_mag   = err_reg[ANGLE_W-1] ? (ANGLE_W+1)'(-(ANGLE_W+1)'(err_reg))
                                       : (ANGLE_W+1)'(err_reg);
        integ_sum = (INTEG_W+1)'(integ_reg) + (INTEG_W+1)'(err_reg);
        if (err_mag >= (ANGLE_W+1)'(window_reg))
            integ_next = '0;
        else if (integ_sum > (INTEG_W+1)'(INTEG_LIMIT))
            integ_next = INTEG_LIMIT;
        else if (integ_sum < -(INTEG_W+1)'(INTEG_LIMIT))
            integ_next = -INTEG_LIMIT;
        else
            integ_next = integ_sum[INTEG_W-1:0];
    end

    // Operand select for the shared multiplier
    logic [ANGLE_W:0]   deriv_mag;
    logic [GAIN_W-1:0]  mul_gain;
    logic [MAG_W-1:0]   mul_mag;
    logic               mul_neg;
    logic [CHUNK_W-1:0] mul_chunk;
    always_comb
    begin
        deriv_mag = deriv_reg[ANGLE_W] ? (ANGLE_W+1)'(-deriv_reg) : (ANGLE_W+1)'(deriv_reg);
        case (mul_step_reg[$clog2(MUL_STEPS)-1:1])
            2'd0:
            begin
                mul_gain = gain_p_reg;
                mul_mag  = MAG_W'(err_mag_reg);
                mul_neg  = err_reg[ANGLE_W-1];
            end
            2'd1:
            begin
                mul_gain = gain_i_reg;
                mul_mag  = integ_reg[INTEG_W-1] ? MAG_W'(-integ_reg) : MAG_W'(integ_reg);
                mul_neg  = integ_reg[INTEG_W-1];
            end
            2'd2:
            begin
                mul_gain = gain_d_reg;
                mul_mag  = MAG_W'(deriv_mag);
                mul_neg  = deriv_reg[ANGLE_W];
            end
            default:
            begin
                mul_gain = '0;
                mul_mag  = '0;
                mul_neg  = 1'b0;
            end
        endcase
        mul_chunk = mul_step_reg[0] ? mul_mag[MAG_W-1:CHUNK_W] : mul_mag[CHUNK_W-1:0];
    end

    // Partial product aligned to its chunk
    logic [ACC_W-1:0] pp_aligned;
    assign pp_aligned = prod_hi_reg ? (ACC_W'(prod_reg) << CHUNK_W) : ACC_W'(prod_reg);

    // Round to nearest, ties away from zero, then clamp to max speed
    logic [RND_W-1:0]   rnd_mag;
    logic [SPEED_W-1:0] lim_mag;
    always_comb
    begin
        rnd_mag = RND_W'((tot_mag_reg + ACC_W'(1 << (RND_SHIFT - 1))) >> RND_SHIFT);
        lim_mag = (rnd_mag > RND_W'(max_reg)) ? max_reg : rnd_mag[SPEED_W-1:0];
    end

    // Turn status from error, derivative and tick count
    status_t fin_status;
    always_comb
    begin
        if (nosens_reg)
            fin_status = STAT_NOSENS;
        else if ((err_mag_reg < (ANGLE_W+1)'(settle_reg))
                 && (deriv_mag < (ANGLE_W+1)'(DERIV_SETTLE)))
            fin_status = STAT_SETTLED;
        else if (tick_reg > timeout_reg)
            fin_status = STAT_TIMEOUT;
        else
            fin_status = STAT_RUN;
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_accept) state_next = S_SUM;
            S_SUM:
            begin
                if (idx_reg == IDX_W'(SENS_NUM - 1))
                    state_next = (cnt_add == '0) ? S_FIN : S_DIV;
            end
            S_DIV:   if (div_cnt_reg == ($bits(div_cnt_reg))'(DIV_CYC - 1)) state_next = S_ERR;
            S_ERR:   state_next = S_WRAP;
            S_WRAP:  state_next = S_INTEG;
            S_INTEG: state_next = S_MUL;
            S_MUL:
            begin
                if (mul_step_reg == ($bits(mul_step_reg))'(MUL_STEPS - 1))
                    state_next = S_DRAIN;
            end
            S_DRAIN: state_next = S_RND1;
            S_RND1:  state_next = S_RND2;
            S_RND2:  state_next = S_FIN;
            S_FIN:   if (fin_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Control state, configuration and controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            prod_vld_reg  <= 1'b0;
            idx_reg       <= '0;
            div_cnt_reg   <= '0;
            mul_step_reg  <= '0;
            nosens_reg    <= 1'b0;
            target_reg    <= RST_TARGET;
            max_reg       <= RST_MAX;
            gain_p_reg    <= RST_GAIN_P;
            gain_i_reg    <= RST_GAIN_I;
            gain_d_reg    <= RST_GAIN_D;
            window_reg    <= RST_WINDOW;
            settle_reg    <= RST_SETTLE;
            timeout_reg   <= RST_TIMEOUT;
            integ_reg     <= '0;
            prev_reg      <= '0;
            tick_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            prod_vld_reg <= (state_reg == S_MUL);

            // Take a register write
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_TARGET:  target_reg  <= cfg_data[ANGLE_W-1:0];
                    REG_MAX:     max_reg     <= cfg_data[SPEED_W-1:0];
                    REG_GAIN_P:  gain_p_reg  <= cfg_data[GAIN_W-1:0];
                    REG_GAIN_I:  gain_i_reg  <= cfg_data[GAIN_W-1:0];
                    REG_GAIN_D:  gain_d_reg  <= cfg_data[GAIN_W-1:0];
                    REG_WINDOW:  window_reg  <= cfg_data[WIN_W-1:0];
                    REG_SETTLE:  settle_reg  <= cfg_data[WIN_W-1:0];
                    REG_TIMEOUT: timeout_reg <= cfg_data[TICK_W-1:0];
                    default:     ;
                endcase
            end

            // Clear the turn state on a start request
            if (in_accept)
            begin
                idx_reg    <= '0;
                nosens_reg <= 1'b0;
                if (in_data.start_turn)
                begin
                    integ_reg <= '0;
                    prev_reg  <= '0;
                    tick_reg  <= '0;
                end
            end

            // Advance the counters
            if (state_reg == S_SUM)
            begin
                idx_reg     <= idx_reg + IDX_W'(1);
                div_cnt_reg <= '0;
                nosens_reg  <= (cnt_add == '0);
            end
            if (state_reg == S_DIV)
                div_cnt_reg <= div_cnt_reg + ($bits(div_cnt_reg))'(1);
            if (state_reg == S_INTEG)
            begin
                integ_reg    <= integ_next;
                mul_step_reg <= '0;
            end
            if (state_reg == S_MUL)
                mul_step_reg <= mul_step_reg + ($bits(mul_step_reg))'(1);

            // Commit the turn state when the result goes out
            if (fin_load && !nosens_reg)
            begin
                prev_reg <= err_reg;
                if (tick_reg != {TICK_W{1'b1}})
                    tick_reg <= tick_reg + TICK_W'(1);
            end

            // Hold the result until taken
            if (fin_load)
                out_valid_reg <= 1'b1;
            else if (out_take)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            ang_reg[0] <= in_data.sensor_one_angle;
            ang_reg[1] <= in_data.sensor_two_angle;
            ang_reg[2] <= in_data.sensor_three_angle;
            ang_reg[3] <= in_data.sensor_four_angle;
            pres_reg   <= {in_data.sensor_four_present, in_data.sensor_three_present,
                           in_data.sensor_two_present, in_data.sensor_one_present};
            sum_reg    <= '0;
            cnt_reg    <= '0;
        end

        if (state_reg == S_SUM)
        begin
            sum_reg     <= sum_add;
            cnt_reg     <= cnt_add;
            sum_neg_reg <= sum_add[SUM_W-1];
            div_reg     <= DIV_W'(sum_mag);
            rem_reg     <= '0;
        end

        if (state_reg == S_DIV)
        begin
            div_reg <= div_next;
            rem_reg <= rem_next;
        end

        if (state_reg == S_ERR)
            diff_reg <= (SUM_W+1)'(target_reg) - (SUM_W+1)'(avg);

        if (state_reg == S_WRAP)
            err_reg <= err_sat;

        if (state_reg == S_INTEG)
        begin
            err_mag_reg <= err_mag;
            deriv_reg   <= (ANGLE_W+1)'(err_reg) - (ANGLE_W+1)'(prev_reg);
        end

        // Issue one partial product per cycle
        if (state_reg == S_MUL)
        begin
            prod_reg     <= PROD_W'(mul_gain) * PROD_W'(mul_chunk);
            prod_neg_reg <= mul_neg;
            prod_hi_reg  <= mul_step_reg[0];
        end

        // Accumulate the registered partial products
        if (state_reg == S_INTEG)
            acc_reg <= '0;
        else if (prod_vld_reg)
            acc_reg <= prod_neg_reg ? acc_reg - $signed(pp_aligned)
                                    : acc_reg + $signed(pp_aligned);

        if (state_reg == S_RND1)
        begin
            tot_neg_reg <= acc_reg[ACC_W-1];
            tot_mag_reg <= acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
        end

        if (state_reg == S_RND2)
            speed_reg <= tot_neg_reg ? -$signed(DRIVE_W'(lim_mag)) : $signed(DRIVE_W'(lim_mag));

        if (fin_load)
        begin
            out_reg.turn_speed  <= nosens_reg ? '0 : speed_reg;
            out_reg.turn_status <= fin_status;
            out_reg.stop_brake  <= (fin_status != STAT_RUN);
        end
    end

    // No-sensor results carry zero drive and brake
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.turn_status == STAT_NOSENS)
        |-> (out_data.turn_speed == '0 && out_data.stop_brake))
        else $error("no-sensor result with drive or without brake");

    // Brake follows any ended turn
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.stop_brake == (out_data.turn_status != STAT_RUN)))
        else $error("brake flag disagrees with status");

    // Drive stays within the configured limit
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((DRIVE_W+1)'(out_data.turn_speed) <= $signed({2'b00, max_reg})
                    && (DRIVE_W+1)'(out_data.turn_speed) >= -$signed({2'b00, max_reg})))
        else $error("drive exceeds max speed");

    // Integral never leaves its saturation range
    assert property (@(posedge clk) disable iff (!rst_n)
        (integ_reg <= INTEG_LIMIT) && (integ_reg >= -INTEG_LIMIT))
        else $error("integral out of range");

    // The divider only runs with a nonzero count
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (cnt_reg != '0))
        else $error("divide by zero count");

endmodule

[test/hptc_checker.sv]
`timescale 1ns / 100ps
// Drive checker for the heading turn controller: tracks registers, predicts and compares.
module hptc_drive_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  hptc_pkg::in_t                   in_data,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  hptc_pkg::out_t                  out_data,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  hptc_pkg::cfg_idx_t              cfg_index,
    input  logic [hptc_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              fail_count,
    output int                              backlog
);
    import hptc_pkg::*;

    // Register copy
    logic signed [ANGLE_W-1:0] reg_target;
    logic [SPEED_W-1:0]        reg_max;
    logic [GAIN_W-1:0]         reg_gp;
    logic [GAIN_W-1:0]         reg_gi;
    logic [GAIN_W-1:0]         reg_gd;
    logic [WIN_W-1:0]          reg_window;
    logic [WIN_W-1:0]          reg_settle;
    logic [TICK_W-1:0]         reg_timeout;

    // Controller state copy
    longint integ_acc;
    longint last_err;
    int     tick_cnt;

    out_t drive_expected[$];
    out_t want;
    int   miss_cnt;

    function automatic longint mag_of(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint clip(input longint v, input longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    // Work out the drive for one tick and advance the state copy
    function automatic out_t steer_tick(input in_t t);
        longint sum;
        longint cnt;
        longint err;
        longint deriv;
        longint total;
        longint mag;
        longint spd;
        out_t   r;
        sum = 0;
        cnt = 0;
        if (t.start_turn)
        begin
            integ_acc = 0;
            last_err  = 0;
            tick_cnt  = 0;
        end
        if (t.sensor_one_present)
        begin
            sum += longint'($signed(t.sensor_one_angle));
            cnt++;
        end
        if (t.sensor_two_present)
        begin
            sum += longint'($signed(t.sensor_two_angle));
            cnt++;
        end
        if (t.sensor_three_present)
        begin
            sum += longint'($signed(t.sensor_three_angle));
            cnt++;
        end
        if (t.sensor_four_present)
        begin
            sum += longint'($signed(t.sensor_four_angle));
            cnt++;
        end

        // No reading at all: zero drive, brake, state untouched
        if (cnt == 0)
        begin
            r.turn_speed  = '0;
            r.turn_status = STAT_NOSENS;
            r.stop_brake  = 1'b1;
            return r;
        end

        // Error to target, wrapped once, then held to 32 bits
        err = longint'(reg_target) - sum / cnt;
        if (err > HALF_TURN)
            err -= FULL_TURN;
        if (err < -HALF_TURN)
            err += FULL_TURN;
        if (err > 64'sd2147483647)
            err = 64'sd2147483647;
        if (err < -64'sd2147483648)
            err = -64'sd2147483648;

        // Accumulate inside the window, drop outside it
        if (mag_of(err) < longint'(reg_window))
            integ_acc = clip(integ_acc + err, longint'(INTEG_LIMIT));
        else
            integ_acc = 0;

        deriv = err - last_err;
        total = longint'(reg_gp) * err + longint'(reg_gi) * integ_acc
              + longint'(reg_gd) * deriv;

        // Round half away from zero, then clamp to the speed limit
        mag = (mag_of(total) + 64'sd32768) >>> RND_SHIFT;
        spd = (total < 0) ? -mag : mag;
        spd = clip(spd, longint'(reg_max));
        last_err = err;

        if (mag_of(err) < longint'(reg_settle) && mag_of(deriv) < DERIV_SETTLE)
            r.turn_status = STAT_SETTLED;
        else if (tick_cnt > int'(reg_timeout))
            r.turn_status = STAT_TIMEOUT;
        else
            r.turn_status = STAT_RUN;
        if (tick_cnt < 65535)
            tick_cnt++;

        r.turn_speed = spd[DRIVE_W-1:0];
        r.stop_brake = (r.turn_status != STAT_RUN);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reg_target  = RST_TARGET;
            reg_max     = RST_MAX;
            reg_gp      = RST_GAIN_P;
            reg_gi      = RST_GAIN_I;
            reg_gd      = RST_GAIN_D;
            reg_window  = RST_WINDOW;
            reg_settle  = RST_SETTLE;
            reg_timeout = RST_TIMEOUT;
            integ_acc   = 0;
            last_err    = 0;
            tick_cnt    = 0;
            miss_cnt    = 0;
            drive_expected.delete();
            fail_count <= 0;
            backlog    <= 0;
        end
        else
        begin
            // Register writes, masked to width; indexes past the list are dropped
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_TARGET:  reg_target  = cfg_data[ANGLE_W-1:0];
                    REG_MAX:     reg_max     = cfg_data[SPEED_W-1:0];
                    REG_GAIN_P:  reg_gp      = cfg_data[GAIN_W-1:0];
                    REG_GAIN_I:  reg_gi      = cfg_data[GAIN_W-1:0];
                    REG_GAIN_D:  reg_gd      = cfg_data[GAIN_W-1:0];
                    REG_WINDOW:  reg_window  = cfg_data[WIN_W-1:0];
                    REG_SETTLE:  reg_settle  = cfg_data[WIN_W-1:0];
                    REG_TIMEOUT: reg_timeout = cfg_data[TICK_W-1:0];
                    default: ;
                endcase
            end

            // Compare each delivered drive against the oldest prediction
            if (out_valid && !out_stall)
            begin
                if (drive_expected.size() == 0)
                begin
                    if (miss_cnt < 10)
                        $display("%0t: drive with no request outstanding:", $time,
                                 " speed %0d status %0d brake %0b",
                                 out_data.turn_speed, out_data.turn_status,
                                 out_data.stop_brake);
                    miss_cnt++;
                end
                else
                begin
                    want = drive_expected.pop_front();
                    if (out_data.turn_speed !== want.turn_speed
                        || out_data.turn_status !== want.turn_status
                        || out_data.stop_brake !== want.stop_brake)
                    begin
                        if (miss_cnt < 10)
                            $display("%0t: drive mismatch:", $time,
                                     " expected speed %0d status %0d brake %0b,",
                                     want.turn_speed, want.turn_status, want.stop_brake,
                                     " got speed %0d status %0d brake %0b",
                                     out_data.turn_speed, out_data.turn_status,
                                     out_data.stop_brake);
                        miss_cnt++;
                    end
                end
            end

            // Predict each accepted request
            if (in_valid && !in_stall)
                drive_expected.push_back(steer_tick(in_data));

            fail_count <= miss_cnt;
            backlog    <= drive_expected.size();
        end
    end

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// Top of the heading turn controller testbench: clock, reset, stimulus and verdict.
module tb_top;
    import hptc_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    in_t                   in_data   = '0;
    logic                  out_stall = 1'b0;
    logic                  cfg_valid = 1'b0;
    cfg_idx_t              cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_stall;
    logic                  out_valid;
    logic                  cfg_ready;
    out_t                  out_data;
    int                    fail_count;
    int                    backlog;
    int                    cycle_cnt = 0;
    longint                cur_target = 0;
    bit                    quiet_in = 1'b0;

    heading_pid_turn_controller u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    hptc_drive_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .backlog    (backlog)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Idle length: mostly short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        if (r < 93)
            return $urandom_range(3, 8);
        return $urandom_range(15, 60);
    endfunction

    function automatic in_t make_tick(input logic s, input logic [31:0] a1,
                                      input logic [31:0] a2, input logic [31:0] a3,
                                      input logic [31:0] a4, input logic [3:0] pres);
        in_t t;
        t.start_turn           = s;
        t.sensor_one_angle     = a1;
        t.sensor_two_angle     = a2;
        t.sensor_three_angle   = a3;
        t.sensor_four_angle    = a4;
        t.sensor_one_present   = pres[3];
        t.sensor_two_present   = pres[2];
        t.sensor_three_present = pres[1];
        t.sensor_four_present  = pres[0];
        return t;
    endfunction

    function automatic logic [31:0] reading(input longint h);
        return 32'(h + longint'($urandom_range(0, 64)) - 32);
    endfunction

    function automatic int pick_gain();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return $urandom_range(0, 65536);
        if (r < 45)
            return 20'hFFFFF;
        if (r < 55)
            return 0;
        return $urandom_range(0, 20'hFFFFF);
    endfunction

    function automatic int pick_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 0;
        if (r < 30)
            return HALF_TURN;
        if (r < 65)
            return $urandom_range(0, 4000);
        return $urandom_range(0, HALF_TURN);
    endfunction

    // Present one request and hold it until accepted
    task automatic push_tick(input in_t t);
        int gap;
        gap = (quiet_in || $urandom_range(0, 1) == 0) ? 0 : idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_data  <= t;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Drop valid and wait until every drive has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (backlog != 0)
            @(posedge clk);
    endtask

    task automatic cfg_write(input cfg_idx_t idx, input logic [31:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Write every register, with junk above each width and stray indexes around
    task automatic load_regs(input logic [31:0] tg, input int mx, input int gp, input int gi,
                             input int gd, input int win, input int st, input int tmo);
        cur_target = longint'($signed(tg));
        cfg_write(cfg_idx_t'(REG_TIMEOUT + 1 + $urandom_range(0, 7)), $urandom);
        cfg_write(REG_TARGET, tg);
        cfg_write(REG_MAX, 32'(mx) | ($urandom << SPEED_W));
        cfg_write(REG_GAIN_P, 32'(gp) | ($urandom << GAIN_W));
        cfg_write(REG_GAIN_I, 32'(gi) | ($urandom << GAIN_W));
        cfg_write(REG_GAIN_D, 32'(gd) | ($urandom << GAIN_W));
        cfg_write(REG_WINDOW, 32'(win) | ($urandom << WIN_W));
        cfg_write(REG_SETTLE, 32'(st) | ($urandom << WIN_W));
        cfg_write(REG_TIMEOUT, 32'(tmo) | ($urandom << TICK_W));
        cfg_write(cfg_idx_t'(REG_TIMEOUT + 1 + $urandom_range(0, 7)), $urandom);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_regs();
        logic [31:0] tg;
        int          mx;
        int          tmo;
        int          r;
        r = $urandom_range(0, 99);
        tg = (r < 20) ? $urandom : 32'($urandom_range(0, 368640)) - 32'd184320;
        r = $urandom_range(0, 99);
        mx = (r < 10) ? 0 : (r < 30) ? 25600 : $urandom_range(1, 25600);
        r = $urandom_range(0, 99);
        if (r < 10)
            tmo = 1;
        else if (r < 20)
            tmo = 65535;
        else if (r < 25)
            tmo = 0;
        else if (r < 65)
            tmo = $urandom_range(2, 40);
        else
            tmo = $urandom_range(41, 300);
        load_regs(tg, mx, pick_gain(), pick_gain(), pick_gain(), pick_span(), pick_span(), tmo);
    endtask

    // Turns: a start tick, then a heading closing on the target, with noise mixed in
    task automatic run_turns(input int n_items);
        int          sent;
        int          len;
        int          step;
        int          k;
        int          r;
        longint      head;
        longint      wrap_off;
        logic [3:0]  pres;
        in_t         t;
        sent = 0;
        while (sent < n_items)
        begin
            len  = $urandom_range(1, 40);
            step = $urandom_range(1, 12);
            head = cur_target + longint'($urandom_range(0, 2 * FULL_TURN)) - FULL_TURN;
            if ($urandom_range(0, 9) == 0)
                head = cur_target + longint'($signed($urandom));
            wrap_off = ($urandom_range(0, 2) == 0)
                     ? FULL_TURN * (longint'($urandom_range(0, 6)) - 3) : 0;
            quiet_in = ($urandom_range(0, 4) == 0);
            for (k = 0; k < len && sent < n_items; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    t = make_tick($urandom_range(0, 1), $urandom, $urandom, $urandom,
                                  $urandom, 4'($urandom));
                end
                else
                begin
                    r = $urandom_range(0, 99);
                    pres = (r < 80) ? 4'hF : (r < 98) ? 4'($urandom_range(1, 15)) : 4'h0;
                    t = make_tick(k == 0, reading(head + wrap_off), reading(head + wrap_off),
                                  reading(head + wrap_off), reading(head + wrap_off), pres);
                end
                push_tick(t);
                sent++;
                head = head + (cur_target - head) * step / 16
                     + longint'($urandom_range(0, 400)) - 200;
            end
        end
        quiet_in = 1'b0;
    endtask

    // Receiver stalls: runs of free cycles, some long, between stalls
    initial
    begin
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            repeat (($urandom_range(0, 6) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 12)) @(posedge clk);
            out_stall <= 1'b1;
            repeat (idle_len()) @(posedge clk);
            out_stall <= 1'b0;
        end
    end

    initial
    begin
        int p;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset registers: sensor subsets, extremes, truncation and wrap edges
        push_tick(make_tick(1'b1, 32'd0, 32'd0, 32'd0, 32'd0, 4'b1111));
        push_tick(make_tick(1'b0, 32'h7FFFFFFF, 32'h80000000, 32'd5, 32'd7, 4'b0000));
        push_tick(make_tick(1'b1, 32'hFFFFFFFF, 32'h12345678, 32'd5, 32'd7, 4'b0000));
        push_tick(make_tick(1'b0, 32'd1000, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 4'b1000));
        push_tick(make_tick(1'b0, 32'd0, -32'sd5000, 32'd0, 32'd0, 4'b0100));
        push_tick(make_tick(1'b0, 32'd0, 32'd0, 32'h7FFFFFFF, 32'd0, 4'b0010));
        push_tick(make_tick(1'b0, 32'd0, 32'd0, 32'd0, 32'h80000000, 4'b0001));
        push_tick(make_tick(1'b0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                            4'b1111));
        push_tick(make_tick(1'b0, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                            4'b1111));
        push_tick(make_tick(1'b0, 32'h7FFFFFFF, 32'h80000000, 32'd0, 32'd0, 4'b1100));
        push_tick(make_tick(1'b0, -32'sd3, 32'd0, -32'sd4, 32'd0, 4'b1010));
        push_tick(make_tick(1'b0, 32'd0, 32'd0, 32'd0, 32'd46081, 4'b0001));
        push_tick(make_tick(1'b0, 32'd0, 32'd0, 32'd0, -32'sd46081, 4'b0001));
        push_tick(make_tick(1'b0, 32'd46080, 32'd0, 32'd0, 32'd0, 4'b1000));
        push_tick(make_tick(1'b0, -32'sd46080, 32'd0, 32'd0, 32'd0, 4'b1000));
        drain();

        // Error saturates high, zero speed limit, timeout of zero
        load_regs(32'h7FFFFFFF, 0, 20'hFFFFF, 20'hFFFFF, 0, HALF_TURN, HALF_TURN, 0);
        push_tick(make_tick(1'b1, 32'h80000000, 32'd0, 32'd0, 32'd0, 4'b1000));
        push_tick(make_tick(1'b0, 32'h80000000, 32'd0, 32'd0, 32'd0, 4'b1000));
        drain();

        // Error saturates low, derivative term only
        load_regs(32'h80000000, 25600, 0, 0, 20'hFFFFF, 0, 0, 0);
        push_tick(make_tick(1'b1, 32'h7FFFFFFF, 32'd0, 32'd0, 32'd0, 4'b1000));
        push_tick(make_tick(1'b0, 32'h7FFFFFFF, 32'd0, 32'd0, 32'd0, 4'b1000));
        drain();

        // Settled wins over timed out
        load_regs(32'd0, 25600, 39322, 131, 26214, 3840, 1000, 0);
        push_tick(make_tick(1'b1, 32'd10, 32'd10, 32'd10, 32'd10, 4'b1111));
        push_tick(make_tick(1'b0, 32'd10, 32'd10, 32'd10, 32'd10, 4'b1111));
        push_tick(make_tick(1'b0, 32'd20000, 32'd20000, 32'd20000, 32'd20000, 4'b1111));
        drain();

        // Random phases, each under its own register setting
        for (p = 0; p < 10; p++)
        begin
            if (p == 0)
                load_regs(RST_TARGET, RST_MAX, RST_GAIN_P, RST_GAIN_I, RST_GAIN_D,
                          RST_WINDOW, RST_SETTLE, RST_TIMEOUT);
            else
                random_regs();
            run_turns(113);
            drain();
        end

        repeat (40) @(posedge clk);
        if (fail_count == 0 && backlog == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
